>>> hdl/lfu_pkg.sv
// shared constants and controller/datapath handshake types for the lfu replacement unit
`default_nettype none

package lfu_pkg;

  localparam int FRAME_COUNT_DEF = 16;

  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 16;
  localparam int FAULT_W = 32;
  localparam int CFG_W   = 5;
  localparam int FIDX_W  = 4;
  localparam int ENTRY_W = PAGE_W + COUNT_W;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [FAULT_W-1:0] FAULT_MAX = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch the word and clear the scan
    logic issue;   // read the next frame entry
    logic commit;  // update the table and present the result
  } lfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_more;   // frames still to be read
    logic scan_end;  // hit found or last frame evaluated
  } lfu_status_t;

endpackage

`default_nettype wire

>>> hdl/lfu_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/lfu_ctrl.sv
// controller state machine for the lfu replacement unit
`default_nettype none

module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire lfu_status_t status_i,
  output lfu_cmd_t         cmd_o,
  output logic             busy_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = status_i.rd_more && !status_i.scan_end;
        if (status_i.scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |=> state_q == ST_IDLE)
    else $error("finish state held for more than one cycle");

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == ST_SCAN)
    else $error("accepted word did not enter the scan");

endmodule

`default_nettype wire

>>> hdl/lfu_datapath.sv
// frame table, scan, victim selection and result registers for the lfu replacement unit
`default_nettype none

module lfu_datapath
  import lfu_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lfu_cmd_t           cmd_i,
  output lfu_status_t             status_o,
  input  wire logic [PAGE_W-1:0]  page_number_i,
  input  wire logic               frames_in_use_we_i,
  input  wire logic [CFG_W-1:0]   frames_in_use_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic [FIDX_W-1:0]       frame_index_o,
  output logic                    evicted_valid_o,
  output logic [PAGE_W-1:0]       evicted_page_o,
  output logic [FAULT_W-1:0]      fault_total_o
);

  localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW = $clog2(FRAME_COUNT + 1);

  logic [CFG_W-1:0]       frames_q;
  logic [FRAME_COUNT-1:0] valid_q;
  logic [FAULT_W-1:0]     fault_q, fault_d;

  logic [PAGE_W-1:0]  page_q;
  logic [CW-1:0]      n_q, n_eff;
  logic [CW-1:0]      rd_num_q;
  logic               ev_pend_q;
  logic [IW-1:0]      ev_idx_q;

  logic               found_q;
  logic [IW-1:0]      hit_idx_q;
  logic [COUNT_W-1:0] hit_count_q;
  logic [COUNT_W-1:0] best_q;
  logic [IW-1:0]      victim_q;
  logic               victim_valid_q;
  logic [PAGE_W-1:0]  victim_page_q;

  logic               done_q;
  logic               res_hit_q;
  logic [FIDX_W-1:0]  res_idx_q;
  logic               res_ev_valid_q;
  logic [PAGE_W-1:0]  res_ev_page_q;
  logic [FAULT_W-1:0] res_fault_q;

  logic [ENTRY_W-1:0] rdata;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  logic               ev_ent_valid;
  logic [PAGE_W-1:0]  ev_page;
  logic [COUNT_W-1:0] ev_count;
  logic               ev_match;
  logic               ev_better;
  logic               ev_last;

  // entry layout: page above count
  lfu_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(FRAME_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.issue),
    .raddr_i(rd_num_q[IW-1:0]),
    .rdata_o(rdata)
  );

  // clamp of the active frame count
  always_comb begin
    if (32'(frames_q) > 32'(FRAME_COUNT)) begin
      n_eff = CW'(FRAME_COUNT);
    end else if (frames_q == '0) begin
      n_eff = CW'(1);
    end else begin
      n_eff = CW'(frames_q);
    end
  end

  assign ev_ent_valid = valid_q[ev_idx_q];
  assign ev_page      = rdata[ENTRY_W-1 -: PAGE_W];
  assign ev_count     = ev_ent_valid ? rdata[COUNT_W-1:0] : '0;
  assign ev_match     = ev_pend_q && ev_ent_valid && (ev_page == page_q);
  assign ev_better    = ev_pend_q && ((ev_idx_q == '0) || (ev_count < best_q));
  assign ev_last      = ev_pend_q && (CW'(ev_idx_q) == (n_q - CW'(1)));

  assign status_o = '{rd_more: (rd_num_q < n_q), scan_end: (ev_match || ev_last)};

  always_comb begin
    fault_d   = (fault_q == FAULT_MAX) ? FAULT_MAX : fault_q + FAULT_W'(1);
    ram_we    = cmd_i.commit;
    ram_waddr = found_q ? hit_idx_q : victim_q;
    if (found_q) begin
      ram_wdata = {page_q,
                   (hit_count_q == COUNT_MAX) ? COUNT_MAX : hit_count_q + COUNT_W'(1)};
    end else begin
      ram_wdata = {page_q, COUNT_W'(1)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q  <= CFG_RESET;
      valid_q   <= '0;
      fault_q   <= '0;
      ev_pend_q <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (frames_in_use_we_i) begin
        frames_q <= frames_in_use_i;
      end
      ev_pend_q <= cmd_i.issue;
      done_q    <= cmd_i.commit;
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (ev_match && !found_q) begin
        found_q <= 1'b1;
      end
      if (cmd_i.commit && !found_q) begin
        valid_q[victim_q] <= 1'b1;
        fault_q           <= fault_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q   <= page_number_i;
      n_q      <= n_eff;
      rd_num_q <= '0;
    end else if (cmd_i.issue) begin
      rd_num_q <= rd_num_q + CW'(1);
    end
    if (cmd_i.issue) begin
      ev_idx_q <= rd_num_q[IW-1:0];
    end
    if (ev_match && !found_q) begin
      hit_idx_q   <= ev_idx_q;
      hit_count_q <= rdata[COUNT_W-1:0];
    end
    if (ev_better && !found_q) begin
      best_q         <= ev_count;
      victim_q       <= ev_idx_q;
      victim_valid_q <= ev_ent_valid;
      victim_page_q  <= ev_page;
    end
    if (cmd_i.commit) begin
      res_hit_q <= found_q;
      if (found_q) begin
        res_idx_q      <= FIDX_W'(hit_idx_q);
        res_ev_valid_q <= 1'b0;
        res_ev_page_q  <= '0;
        res_fault_q    <= fault_q;
      end else begin
        res_idx_q      <= FIDX_W'(victim_q);
        res_ev_valid_q <= victim_valid_q;
        res_ev_page_q  <= victim_valid_q ? victim_page_q : '0;
        res_fault_q    <= fault_d;
      end
    end
  end

  assign done_o          = done_q;
  assign hit_o           = res_hit_q;
  assign frame_index_o   = res_idx_q;
  assign evicted_valid_o = res_ev_valid_q;
  assign evicted_page_o  = res_ev_page_q;
  assign fault_total_o   = res_fault_q;

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(res_hit_q && res_ev_valid_q))
    else $error("hit reported together with an eviction");

  a_fault_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 fault_q >= $past(fault_q))
    else $error("fault counter went backwards");

  a_fill_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !found_q |=> valid_q[$past(victim_q)])
    else $error("filled frame not marked valid");

endmodule

`default_nettype wire

>>> hdl/lfu_page_replacement_unit.sv
// top level of the lfu page replacement unit
`default_nettype none

// lfu page replacement unit: a word on page_number_i is taken when start_i is
// high and busy_o is low. the frame table sits in a single read port ram, so
// the controller walks the active frames one per cycle, comparing tags and
// tracking the lowest use count as it goes. a hit ends the scan early; a miss
// reads every active frame, the active frames numbering frames_in_use clamped
// to 1..FRAME_COUNT. the result is shown on the result ports for exactly one
// cycle with done_o high and must be taken then: there is no way to hold it
// off. frames_in_use is written through frames_in_use_we_i and is to be
// changed only while busy_o is low; frames beyond the active range keep their
// contents and rejoin when the range grows.
module lfu_page_replacement_unit
  import lfu_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // word in
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [PAGE_W-1:0]  page_number_i,
  // configuration
  input  wire logic               frames_in_use_we_i,
  input  wire logic [CFG_W-1:0]   frames_in_use_i,
  // result word
  output logic                    done_o,
  output logic                    hit_o,
  output logic [FIDX_W-1:0]       frame_index_o,
  output logic                    evicted_valid_o,
  output logic [PAGE_W-1:0]       evicted_page_o,
  output logic [FAULT_W-1:0]      fault_total_o
);

  lfu_cmd_t    cmd;
  lfu_status_t status;

  // sequencing: start, frame scan, commit
  lfu_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // frame table, victim search and result registers
  lfu_datapath #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .page_number_i     (page_number_i),
    .frames_in_use_we_i(frames_in_use_we_i),
    .frames_in_use_i   (frames_in_use_i),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .frame_index_o     (frame_index_o),
    .evicted_valid_o   (evicted_valid_o),
    .evicted_page_o    (evicted_page_o),
    .fault_total_o     (fault_total_o)
  );

endmodule

`default_nettype wire
